>>> rtl/core/vms_pkg.sv
`default_nettype none

package vms_pkg;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 5;
  localparam int SUM_W      = 24;
  localparam int D2_W       = 18;
  localparam int ROOT_W     = 35;
  localparam int ROOT_STEPS = 17;
  localparam int STEP_W     = 5;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(64'h1_0000_0000);
  localparam logic [CFG_AW-1:0] REG_DISTANCE_MODE = CFG_AW'(0);

  typedef enum logic [1:0] {
    MODE_NONE      = 2'd0,
    MODE_EUCLID    = 2'd1,
    MODE_MANHATTAN = 2'd2,
    MODE_CHESS     = 2'd3
  } dist_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_RD_J,
    ST_DIFF,
    ST_DIST,
    ST_MUL,
    ST_ROOT,
    ST_ACC,
    ST_CMP,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/vms_if.sv
`default_nettype none

interface vms_in_if import vms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface vms_out_if import vms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] median_index;
  logic [PIX_W-1:0] median_red;
  logic [PIX_W-1:0] median_green;
  logic [PIX_W-1:0] median_blue;
  logic             overflow;

  modport source (output valid, median_index, median_red, median_green, median_blue,
                  overflow, input ready);
  modport sink (input valid, median_index, median_red, median_green, median_blue,
                overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vms_ram.sv
`default_nettype none

module vms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vector_median_select_unit.sv
// Vector median selector for a neighborhood of RGB pixels.
// Pixels arrive on in_bus, one per beat, and are stored in load order in a
// small RAM. A beat with last_pixel set closes the neighborhood. The block
// then sums, for each stored pixel, its distances to all other stored pixels
// and returns on out_bus one beat with the index and color of the pixel with
// the smallest sum (the earliest on a tie) and the overflow flag. Pixels
// beyond MAX_POINTS are dropped and raise overflow. The distance mode is set
// through the APB port at byte address 0 (1 Euclidean, 2 Manhattan,
// 3 chessboard, 0 all zero) and resets to Euclidean.
// After the last beat, one shared datapath (an 8x8 multiplier and a
// 2-bit-per-cycle square root) walks all ordered pairs of stored pixels;
// in_bus is not ready during that time.
// The result sits in an output register; new pixels are taken while it waits,
// and the next result waits until the receiver takes the previous one.
// Reset is synchronous and clears the pixel count, overflow and out valid.

`default_nettype none

module vector_median_select_unit import vms_pkg::*; #(
  parameter int MAX_POINTS = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  vms_in_if.sink                 in_bus,
  vms_out_if.source              out_bus,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 3 * PIX_W;

  state_t            state_r, state_nxt;
  dist_mode_t        mode_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PW-1:0]     pi_r, pi_nxt;
  logic [PIX_W-1:0]  dr_r, dr_nxt, dg_r, dg_nxt, db_r, db_nxt;
  logic [D2_W-1:0]   d2_r, d2_nxt;
  logic [ROOT_W-1:0] rem_r, rem_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt, best_sum_r, best_sum_nxt;
  logic [CW-1:0]     best_idx_r, best_idx_nxt;
  logic [PW-1:0]     best_pix_r, best_pix_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [PW-1:0]     out_pix_r, out_pix_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              in_acc, ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [PW-1:0]     ram_rdata;
  logic              store_full, last_i, emit_go, root_ge;
  logic [PIX_W-1:0]  pj_r, pj_g, pj_b, mul_a, m_rg;
  logic [2*PIX_W-1:0] sq;
  logic [SUM_W-1:0]  pair_dist;
  logic [ROOT_W-1:0] trial;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign store_full   = (count_r == CW'(MAX_POINTS));
  assign ram_we       = in_acc && !store_full;
  assign last_i       = (CW'(i_r + 1'b1) == count_r);
  assign emit_go      = !out_valid_r || out_bus.ready;

  vms_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_bus.red, in_bus.green, in_bus.blue}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pj_r  = ram_rdata[PW-1 -: PIX_W];
  assign pj_g  = ram_rdata[2*PIX_W-1 -: PIX_W];
  assign pj_b  = ram_rdata[PIX_W-1:0];
  assign m_rg  = (dr_r > dg_r) ? dr_r : dg_r;
  assign trial = res_r + bit_r;
  assign root_ge = (rem_r >= trial);
  assign sq    = mul_a * mul_a;

  always_comb begin
    case (step_r)
      STEP_W'(0): mul_a = dr_r;
      STEP_W'(1): mul_a = dg_r;
      default:    mul_a = db_r;
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_MANHATTAN: pair_dist = SUM_W'(dr_r) + SUM_W'(dg_r) + SUM_W'(db_r);
      MODE_CHESS:     pair_dist = SUM_W'((m_rg > db_r) ? m_rg : db_r);
      default:        pair_dist = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_bus.last_pixel) begin
          state_nxt = ST_RD_I;
        end
      end
      ST_RD_I: state_nxt = ST_LD_I;
      ST_LD_I: state_nxt = ST_RD_J;
      ST_RD_J: begin
        if (j_r == count_r) begin
          state_nxt = ST_CMP;
        end else if (j_r != i_r) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_DIST;
      ST_DIST: state_nxt = (mode_r == MODE_EUCLID) ? ST_MUL : ST_RD_J;
      ST_MUL: begin
        if (step_r == STEP_W'(2)) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: state_nxt = ST_RD_J;
      ST_CMP: state_nxt = last_i ? ST_EMIT : ST_RD_I;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    step_nxt      = step_r;
    pi_nxt        = pi_r;
    dr_nxt        = dr_r;
    dg_nxt        = dg_r;
    db_nxt        = db_r;
    d2_nxt        = d2_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    sum_nxt       = sum_r;
    best_sum_nxt  = best_sum_r;
    best_idx_nxt  = best_idx_r;
    best_pix_nxt  = best_pix_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_idx_nxt   = out_idx_r;
    out_pix_nxt   = out_pix_r;
    out_ovf_nxt   = out_ovf_r;
    ram_re        = 1'b0;
    ram_raddr     = i_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        if (in_acc) begin
          if (store_full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = CW'(count_r + 1'b1);
          end
        end
      end
      ST_RD_I: begin
        ram_re = 1'b1;
      end
      ST_LD_I: begin
        pi_nxt  = ram_rdata;
        sum_nxt = '0;
        j_nxt   = '0;
      end
      ST_RD_J: begin
        ram_raddr = j_r[AW-1:0];
        if (j_r != count_r) begin
          if (j_r == i_r) begin
            j_nxt = CW'(j_r + 1'b1);
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        dr_nxt = (pi_r[PW-1 -: PIX_W] >= pj_r) ? pi_r[PW-1 -: PIX_W] - pj_r
                                               : pj_r - pi_r[PW-1 -: PIX_W];
        dg_nxt = (pi_r[2*PIX_W-1 -: PIX_W] >= pj_g) ? pi_r[2*PIX_W-1 -: PIX_W] - pj_g
                                                    : pj_g - pi_r[2*PIX_W-1 -: PIX_W];
        db_nxt = (pi_r[PIX_W-1:0] >= pj_b) ? pi_r[PIX_W-1:0] - pj_b
                                           : pj_b - pi_r[PIX_W-1:0];
      end
      ST_DIST: begin
        step_nxt = '0;
        d2_nxt   = '0;
        if (mode_r != MODE_EUCLID) begin
          sum_nxt = sum_r + pair_dist;
          j_nxt   = CW'(j_r + 1'b1);
        end
      end
      ST_MUL: begin
        d2_nxt = d2_r + D2_W'(sq);
        if (step_r == STEP_W'(2)) begin
          step_nxt = '0;
          rem_nxt  = ROOT_W'({d2_nxt, 16'h0000});
          res_nxt  = '0;
          bit_nxt  = ROOT_BIT0;
        end else begin
          step_nxt = STEP_W'(step_r + 1'b1);
        end
      end
      ST_ROOT: begin
        step_nxt = STEP_W'(step_r + 1'b1);
        bit_nxt  = bit_r >> 2;
        if (root_ge) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
      end
      ST_ACC: begin
        sum_nxt = sum_r + res_r[SUM_W-1:0];
        j_nxt   = CW'(j_r + 1'b1);
      end
      ST_CMP: begin
        if (i_r == '0 || sum_r < best_sum_r) begin
          best_sum_nxt = sum_r;
          best_idx_nxt = i_r;
          best_pix_nxt = pi_r;
        end
        i_nxt = CW'(i_r + 1'b1);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(best_idx_r);
          out_pix_nxt   = best_pix_r;
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_EUCLID;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && paddr == REG_DISTANCE_MODE) begin
        mode_r <= dist_mode_t'(pwdata[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    pi_r       <= pi_nxt;
    dr_r       <= dr_nxt;
    dg_r       <= dg_nxt;
    db_r       <= db_nxt;
    d2_r       <= d2_nxt;
    rem_r      <= rem_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    sum_r      <= sum_nxt;
    best_sum_r <= best_sum_nxt;
    best_idx_r <= best_idx_nxt;
    best_pix_r <= best_pix_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pix_r  <= out_pix_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DISTANCE_MODE) ? CFG_DW'(mode_r) : '0;

  assign out_bus.valid        = out_valid_r;
  assign out_bus.median_index = out_idx_r;
  assign out_bus.median_red   = out_pix_r[PW-1 -: PIX_W];
  assign out_bus.median_green = out_pix_r[2*PIX_W-1 -: PIX_W];
  assign out_bus.median_blue  = out_pix_r[PIX_W-1:0];
  assign out_bus.overflow     = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("Pixel count exceeds the store depth.");

  a_last_starts_select: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.last_pixel |=> state_r == ST_RD_I && count_r != '0)
    else $error("A last beat did not start a selection over a nonempty store.");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> best_idx_r < count_r)
    else $error("Selected index lies outside the stored pixels.");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && emit_go |=> out_valid_r && state_r == ST_IDLE && count_r == '0)
    else $error("A finished selection was not handed to the output register.");

endmodule

`default_nettype wire
